/* hw/rtl/bitmap_set_test_count_find_macros.svh */
// assertion macros of the bit store rtl, used by the back end
`ifndef BITMAP_SET_TEST_COUNT_FIND_MACROS_SVH
`define BITMAP_SET_TEST_COUNT_FIND_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSTCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BSTCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bstcf_pkg.sv */
// shared constants, types and helper functions of the bit store
package bstcf_pkg;

	// store geometry
	localparam int MAX_BITS   = 1024;
	localparam int WORD_BITS  = 64;
	localparam int NUM_WORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W    = $clog2(NUM_WORDS);
	localparam int WCNT_W     = $clog2(NUM_WORDS + 1);
	localparam int OFF_W      = $clog2(WORD_BITS);
	localparam int BYTE_LANES = WORD_BITS / 8;
	localparam int LANE_W     = $clog2(BYTE_LANES);
	localparam int WSUM_W     = $clog2(WORD_BITS + 1);
	localparam int BYTE_ROUND = 7;

	// field widths
	localparam int ACTION_W = 3;
	localparam int BIT_W    = 10;
	localparam int BYTE_W   = 7;
	localparam int VAL_W    = 8;
	localparam int LEN_W    = 11;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	// command queue
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// action codes on the request channel
	localparam logic [ACTION_W-1:0] ACT_SET   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CLR   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_TEST  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_COUNT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_FIND  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_BYTE  = 3'd5;

	// decoded operation for the back end
	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_TEST,
		OP_COUNT,
		OP_FIND
	} op_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t                  op;
		logic                 apply;
		logic [WADDR_W-1:0]   word;
		logic [OFF_W-1:0]     off;
		logic [WORD_BITS-1:0] wmask;
		logic [WORD_BITS-1:0] wdata;
		logic [BIT_W-1:0]     start;
		logic [LEN_W-1:0]     len;
		logic [WCNT_W-1:0]    end_word;
	} cmd_t;

	// number of set bits in one byte
	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(b[i]);
		end
		return n;
	endfunction

	// position of the lowest set bit in one byte, zero when empty
	function automatic logic [2:0] low8(input logic [7:0] b);
		logic [2:0] p;
		p = '0;
		for (int i = 7; i >= 0; i--) begin
			if (b[i]) begin
				p = 3'(i);
			end
		end
		return p;
	endfunction

endpackage

/* hw/rtl/bstcf_if.sv */
// request and response channel interfaces of the bit store
interface bstcf_req_if import bstcf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BIT_W-1:0]    bit_index;
	logic [BYTE_W-1:0]   byte_index;
	logic [VAL_W-1:0]    byte_value;

	modport source (output valid, action, bit_index, byte_index, byte_value, input ready);
	modport sink (input valid, action, bit_index, byte_index, byte_value, output ready);
endinterface

interface bstcf_rsp_if import bstcf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             bit_value;
	logic [LEN_W-1:0] set_count;
	logic             found;
	logic [BIT_W-1:0] found_index;

	modport source (output valid, bit_value, set_count, found, found_index, input ready);
	modport sink (input valid, bit_value, set_count, found, found_index, output ready);
endinterface

/* hw/rtl/bstcf_ram.sv */
// generic single write port ram with registered read
module bstcf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/bstcf_front.sv */
// front end: takes request items and classifies them into commands
module bstcf_front import bstcf_pkg::*; (
	bstcf_req_if.sink        req,
	input  logic [LEN_W-1:0] bit_length,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd
);

	logic [LEN_W-1:0]     len;
	logic [LEN_W-1:0]     len_round;
	logic [BIT_W-1:0]     byte_pos;
	logic [WORD_BITS-1:0] bit_one;
	logic [WORD_BITS-1:0] byte_ones;
	logic [WORD_BITS-1:0] byte_val;
	logic                 bit_ok;
	logic                 byte_ok;

	// handshake passes straight to the queue
	assign req.ready = cmd_ready;
	assign cmd_valid = req.valid;

	// length in use and range checks
	assign len       = (bit_length > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : bit_length;
	assign len_round = (len + LEN_W'(BYTE_ROUND)) >> 3;
	assign byte_pos  = {req.byte_index, 3'b000};
	assign bit_ok    = LEN_W'(req.bit_index) < len;
	assign byte_ok   = LEN_W'(req.byte_index) < len_round;

	// masks for single bit and byte lane writes
	assign bit_one   = WORD_BITS'(1) << req.bit_index[OFF_W-1:0];
	assign byte_ones = WORD_BITS'(8'hff) << byte_pos[OFF_W-1:0];
	assign byte_val  = WORD_BITS'(req.byte_value) << byte_pos[OFF_W-1:0];

	// classify the item
	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.start    = req.bit_index;
		cmd.len      = len;
		cmd.end_word = WCNT_W'((len + LEN_W'(WORD_BITS - 1)) >> OFF_W);
		cmd.word     = WADDR_W'(req.bit_index >> OFF_W);
		cmd.off      = req.bit_index[OFF_W-1:0];
		case (req.action)
			ACT_SET: begin
				cmd.op    = OP_WRITE;
				cmd.apply = bit_ok;
				cmd.wmask = bit_one;
				cmd.wdata = bit_one;
			end
			ACT_CLR: begin
				cmd.op    = OP_WRITE;
				cmd.apply = bit_ok;
				cmd.wmask = bit_one;
			end
			ACT_TEST: begin
				cmd.op    = OP_TEST;
				cmd.apply = bit_ok;
			end
			ACT_COUNT: begin
				cmd.op    = OP_COUNT;
				cmd.apply = 1'b1;
			end
			ACT_FIND: begin
				cmd.op    = OP_FIND;
				cmd.apply = bit_ok;
			end
			ACT_BYTE: begin
				cmd.op    = OP_WRITE;
				cmd.apply = byte_ok;
				cmd.word  = WADDR_W'(byte_pos >> OFF_W);
				cmd.wmask = byte_ones;
				cmd.wdata = byte_val;
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

endmodule

/* hw/rtl/bstcf_fifo.sv */
// short command queue between front and back end
module bstcf_fifo import bstcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	cmd_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  push;
	logic                  pop;

	assign wr_ready = count_q != FIFO_CNT_W'(FIFO_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

endmodule

/* hw/rtl/bstcf_back.sv */
// back end: word store, read-modify-write and count/find scan
`include "bitmap_set_test_count_find_macros.svh"

module bstcf_back import bstcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	bstcf_rsp_if.source rsp
);

	state_t               state_q;
	state_t               state_d;
	cmd_t                 cur_q;
	logic [NUM_WORDS-1:0] vld_q;
	logic [WCNT_W-1:0]    ptr_q;
	logic [WCNT_W-1:0]    end_q;

	// scan pipeline
	logic                 v_s1;
	logic [WADDR_W-1:0]   addr_s1;
	logic                 v_s2;
	logic [WADDR_W-1:0]   addr_s2;
	logic [3:0]           cnt_s2 [BYTE_LANES];
	logic                 nz_s2  [BYTE_LANES];
	logic [2:0]           low_s2 [BYTE_LANES];

	// result
	logic                 bit_q;
	logic [LEN_W-1:0]     acc_q;
	logic                 found_q;
	logic [BIT_W-1:0]     fidx_q;
	logic                 out_vld_q;

	// ram hookup
	logic                 ram_we;
	logic                 ram_re;
	logic [WADDR_W-1:0]   ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] old_word;
	logic [WORD_BITS-1:0] new_word;

	// sequencer outputs
	logic                 issue;
	logic                 drained;
	logic                 load;

	// stage one and two logic
	logic [WORD_BITS-1:0] word_s1;
	logic [WORD_BITS-1:0] lmask;
	logic [WORD_BITS-1:0] smask;
	logic [WORD_BITS-1:0] masked_s1;
	logic [LEN_W-1:0]     lo_s1;
	logic [LEN_W-1:0]     rem_s1;
	logic [WSUM_W-1:0]    sum_s2;
	logic                 hit_s2;
	logic [LANE_W-1:0]    lane_s2;

	bstcf_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q.word),
		.wdata (new_word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read-modify-write word; unwritten words read as zero
	assign old_word = vld_q[cur_q.word] ? ram_rdata : '0;
	assign new_word = (old_word & ~cur_q.wmask) | (cur_q.wdata & cur_q.wmask);

	assign issue   = ptr_q < end_q;
	assign drained = !issue && !v_s1 && !v_s2;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (!cmd.apply || cmd.op == OP_NONE) begin
						state_d = ST_FINISH;
					end else if (cmd.op == OP_COUNT || cmd.op == OP_FIND) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ:   state_d = ST_MODIFY;
			ST_MODIFY: state_d = ST_FINISH;
			ST_SCAN: begin
				if (drained) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = cur_q.word;
		load      = 1'b0;
		case (state_q)
			ST_IDLE:   cmd_ready = 1'b1;
			ST_READ:   ram_re = 1'b1;
			ST_MODIFY: ram_we = cur_q.op == OP_WRITE;
			ST_SCAN: begin
				ram_re    = issue;
				ram_raddr = WADDR_W'(ptr_q);
			end
			ST_FINISH: load = !out_vld_q || rsp.ready;
			default: ;
		endcase
	end

	// stage one: mask the word to the length and the find start
	assign word_s1 = vld_q[addr_s1] ? ram_rdata : '0;
	assign lo_s1   = LEN_W'(addr_s1) << OFF_W;
	assign rem_s1  = cur_q.len - lo_s1;
	assign lmask   = (cur_q.len >= lo_s1 + LEN_W'(WORD_BITS)) ? '1 :
		~({WORD_BITS{1'b1}} << rem_s1[OFF_W-1:0]);
	assign smask   = (cur_q.op == OP_FIND && addr_s1 == WADDR_W'(cur_q.start >> OFF_W)) ?
		({WORD_BITS{1'b1}} << cur_q.start[OFF_W-1:0]) : '1;
	assign masked_s1 = word_s1 & lmask & smask;

	// stage two: sum lane counts and pick the lowest lane with a set bit
	always_comb begin
		sum_s2  = '0;
		hit_s2  = 1'b0;
		lane_s2 = '0;
		for (int l = 0; l < BYTE_LANES; l++) begin
			sum_s2 = sum_s2 + WSUM_W'(cnt_s2[l]);
		end
		for (int l = BYTE_LANES - 1; l >= 0; l--) begin
			if (nz_s2[l]) begin
				hit_s2  = 1'b1;
				lane_s2 = LANE_W'(l);
			end
		end
	end

	// per lane statistics register
	always_ff @(posedge clk) begin
		for (int l = 0; l < BYTE_LANES; l++) begin
			cnt_s2[l] <= pop8(masked_s1[8*l +: 8]);
			nz_s2[l]  <= |masked_s1[8*l +: 8];
			low_s2[l] <= low8(masked_s1[8*l +: 8]);
		end
		addr_s2 <= addr_s1;
	end

	// control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_q     <= '0;
			vld_q     <= '0;
			ptr_q     <= '0;
			end_q     <= '0;
			v_s1      <= 1'b0;
			addr_s1   <= '0;
			v_s2      <= 1'b0;
			bit_q     <= 1'b0;
			acc_q     <= '0;
			found_q   <= 1'b0;
			fidx_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= state_q == ST_SCAN && issue;
			v_s2    <= v_s1;
			if (state_q == ST_SCAN && issue) begin
				addr_s1 <= WADDR_W'(ptr_q);
				ptr_q   <= ptr_q + WCNT_W'(1);
			end
			// take a new command
			if (state_q == ST_IDLE && cmd_valid) begin
				cur_q   <= cmd;
				bit_q   <= 1'b0;
				acc_q   <= '0;
				found_q <= 1'b0;
				fidx_q  <= '0;
				end_q   <= cmd.end_word;
				ptr_q   <= (cmd.op == OP_FIND) ? WCNT_W'(cmd.start >> OFF_W) : '0;
			end
			// test read or word write
			if (state_q == ST_MODIFY) begin
				if (cur_q.op == OP_TEST) begin
					bit_q <= old_word[cur_q.off];
				end else begin
					vld_q[cur_q.word] <= 1'b1;
				end
			end
			// accumulate scan results
			if (v_s2) begin
				if (cur_q.op == OP_COUNT) begin
					acc_q <= acc_q + LEN_W'(sum_s2);
				end
				if (cur_q.op == OP_FIND && hit_s2 && !found_q) begin
					found_q <= 1'b1;
					fidx_q  <= BIT_W'({addr_s2, lane_s2, low_s2[lane_s2]});
				end
			end
			// response register
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (load) begin
			rsp.bit_value   <= bit_q;
			rsp.set_count   <= acc_q;
			rsp.found       <= found_q;
			rsp.found_index <= fidx_q;
		end
	end

	assign rsp.valid = out_vld_q;

	`BSTCF_ASSERT_NOW(a_scan_bound, state_q == ST_SCAN, ptr_q <= end_q, "scan pointer ran past end")
	`BSTCF_ASSERT_NOW(a_count_bound, 1'b1, acc_q <= cur_q.len, "count exceeds length in use")
	`BSTCF_ASSERT_NOW(a_find_range, found_q,
		fidx_q >= cur_q.start && LEN_W'(fidx_q) < cur_q.len, "find index out of range")

endmodule

/* hw/rtl/bitmap_set_test_count_find.sv */
// top level of the bit store with set, clear, test, count and find
//
//  channel  dir  handshake        payload
//  req      in   valid/ready      action, bit_index, byte_index, byte_value
//  rsp      out  valid/ready      bit_value, set_count, found, found_index
//  cfg      in   cfg_we           cfg_wdata (bit_length)
//
// set, clear, test and byte write pass through the read, modify and finish states to the
// response; an item that is dropped, out of range or an unused action goes straight to finish.
// count and find scan one word per cycle through the scan pipeline; the single read port
// of the word ram sets this rate.
// reset clears the word store through one valid flop per word; no sweep.
// a two-entry command queue lets requests be taken while the back end works
// and one response register lets the back end finish while rsp is stalled.
module bitmap_set_test_count_find import bstcf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	bstcf_req_if.sink        req,
	bstcf_rsp_if.source      rsp
);

	logic [LEN_W-1:0] bit_length_q;
	logic             front_valid;
	logic             front_ready;
	cmd_t             front_cmd;
	logic             back_valid;
	logic             back_ready;
	cmd_t             back_cmd;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_length_q <= LEN_RESET;
		end else if (cfg_we) begin
			bit_length_q <= cfg_wdata;
		end
	end

	bstcf_front u_front (
		.req        (req),
		.bit_length (bit_length_q),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	bstcf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_data  (front_cmd),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_data  (back_cmd)
	);

	bstcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.rsp       (rsp)
	);

endmodule

/* test/bitmap_answer_check.sv */
// response checker of the bit store: shadow copy of the bits, expected answers, field compare
module bitmap_answer_check import bstcf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	bstcf_req_if             req,
	bstcf_rsp_if             rsp,
	output int               fail_count,
	output int               pending,
	output int               checked
);

	typedef struct packed {
		logic             bit_value;
		logic [LEN_W-1:0] set_count;
		logic             found;
		logic [BIT_W-1:0] found_index;
	} bit_answer_t;

	logic [MAX_BITS-1:0] shadow_bits;
	logic [LEN_W-1:0]    shadow_len;
	bit_answer_t         expected_answers[$];

	// apply one item to the shadow bits and work out its answer
	task automatic predict_bit_action(
		input  logic [ACTION_W-1:0] act,
		input  logic [BIT_W-1:0]    idx,
		input  logic [BYTE_W-1:0]   bpos,
		input  logic [VAL_W-1:0]    bval,
		output bit_answer_t         ans
	);
		int ulen;
		ans = '0;
		// length in use saturates at the physical store size
		ulen = (shadow_len > LEN_W'(MAX_BITS)) ? MAX_BITS : int'(shadow_len);
		case (act)
			ACT_SET: begin
				if (int'(idx) < ulen) shadow_bits[idx] = 1'b1;
			end
			ACT_CLR: begin
				if (int'(idx) < ulen) shadow_bits[idx] = 1'b0;
			end
			ACT_TEST: begin
				if (int'(idx) < ulen) ans.bit_value = shadow_bits[idx];
			end
			ACT_COUNT: begin
				for (int p = 0; p < ulen; p++) begin
					ans.set_count = ans.set_count + LEN_W'(shadow_bits[p]);
				end
			end
			ACT_FIND: begin
				for (int p = int'(idx); p < ulen; p++) begin
					if (!ans.found && shadow_bits[p]) begin
						ans.found       = 1'b1;
						ans.found_index = BIT_W'(p);
					end
				end
			end
			ACT_BYTE: begin
				// bytes past the rounded-up length are dropped, bits past length stay stored
				if (int'(bpos) < ((ulen + BYTE_ROUND) >> 3)) begin
					shadow_bits[int'(bpos) * 8 +: 8] = bval;
				end
			end
			default: begin
			end
		endcase
	endtask

	// track config, compare responses in order, predict accepted items
	always @(posedge clk or negedge arst_n) begin
		bit_answer_t got;
		bit_answer_t want;
		if (!arst_n) begin
			shadow_bits = '0;
			shadow_len  = LEN_RESET;
			expected_answers.delete();
			fail_count  = 0;
			pending     = 0;
			checked     = 0;
		end else begin
			if (cfg_we) shadow_len = cfg_wdata;

			// response side
			if (rsp.valid && rsp.ready) begin
				got = {rsp.bit_value, rsp.set_count, rsp.found, rsp.found_index};
				if (expected_answers.size() == 0) begin
					fail_count++;
					$error("response with no item waiting");
				end else begin
					want = expected_answers.pop_front();
					checked++;
					if (got.bit_value !== want.bit_value) begin
						fail_count++;
						$error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
					end
					if (got.set_count !== want.set_count) begin
						fail_count++;
						$error("set_count: expected %0d, got %0d", want.set_count, got.set_count);
					end
					if (got.found !== want.found) begin
						fail_count++;
						$error("found: expected %0d, got %0d", want.found, got.found);
					end
					if (got.found_index !== want.found_index) begin
						fail_count++;
						$error("found_index: expected %0d, got %0d",
							want.found_index, got.found_index);
					end
				end
			end

			// request side
			if (req.valid && req.ready) begin
				predict_bit_action(req.action, req.bit_index, req.byte_index, req.byte_value,
					want);
				expected_answers.push_back(want);
			end
			pending = expected_answers.size();
		end
	end

endmodule

/* test/tb_bitmap_set_test_count_find.sv */
// testbench top of the bit store: stimulus, response stalls, length settings and verdict
module tb_bitmap_set_test_count_find;
	import bstcf_pkg::*;

	// action codes the block leaves unused
	localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES = 14;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	bit               steady;
	bit               hold_request;
	int               fail_count;
	int               pending;
	int               checked;
	int               cycles = 0;
	int               items_sent = 0;
	int               settings_used = 0;
	int               cur_len = 1024;

	bstcf_req_if req_ch ();
	bstcf_rsp_if rsp_ch ();

	bitmap_set_test_count_find u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	bitmap_answer_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_bitmap_set_test_count_find: errors");
			$finish;
		end
	end

	// response side: random stalls, plus one long hold-off when asked
	initial begin
		bit hold_taken;
		hold_taken   = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken   = 1'b1;
				rsp_ch.ready = 1'b0;
				repeat (80) @(negedge clk);
			end else begin
				rsp_ch.ready = steady || ($urandom_range(0, 99) >= 12);
			end
		end
	end

	// offer one item, called at a falling edge; valid stays high on return
	task automatic send_item(
		input logic [ACTION_W-1:0] act,
		input logic [BIT_W-1:0]    idx,
		input logic [BYTE_W-1:0]   bpos,
		input logic [VAL_W-1:0]    bval
	);
		while (!steady && $urandom_range(0, 99) < 12) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.action     = act;
		req_ch.bit_index  = idx;
		req_ch.byte_index = bpos;
		req_ch.byte_value = bval;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// stop offering and wait for every outstanding answer
	task automatic drain_answers();
		req_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// change the length in use once the block is idle
	task automatic set_length(input int len);
		drain_answers();
		cfg_we    = 1'b1;
		cfg_wdata = LEN_W'(len);
		@(negedge clk);
		cfg_we = 1'b0;
		cur_len = len;
		settings_used++;
	endtask

	// random items, indices mostly inside the length in use
	task automatic run_random_phase(input int n_items);
		int                  ulen;
		int                  nbytes;
		int                  r;
		logic [ACTION_W-1:0] act;
		logic [BIT_W-1:0]    idx;
		logic [BYTE_W-1:0]   bpos;
		ulen   = (cur_len > MAX_BITS) ? MAX_BITS : cur_len;
		nbytes = (ulen + BYTE_ROUND) >> 3;
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 25)      act = ACT_SET;
			else if (r < 40) act = ACT_CLR;
			else if (r < 60) act = ACT_TEST;
			else if (r < 70) act = ACT_COUNT;
			else if (r < 85) act = ACT_FIND;
			else if (r < 95) act = ACT_BYTE;
			else if (r < 97) act = ACT_SPARE_A;
			else             act = ACT_SPARE_B;
			if (ulen > 0 && $urandom_range(0, 99) < 85)
				idx = BIT_W'($urandom_range(0, ulen - 1));
			else
				idx = BIT_W'($urandom);
			if (nbytes > 0 && $urandom_range(0, 99) < 85)
				bpos = BYTE_W'($urandom_range(0, nbytes - 1));
			else
				bpos = BYTE_W'($urandom);
			send_item(act, idx, bpos, VAL_W'($urandom));
		end
	endtask

	// main stimulus
	initial begin
		int phase_len[PHASES];
		int phase_items[PHASES];

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		steady            = 1'b0;
		hold_request      = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_SET;
		req_ch.bit_index  = '0;
		req_ch.byte_index = '0;
		req_ch.byte_value = '0;
		phase_len   = '{1024, 2047, 0, 1023, 1, 7, 8, 9, 63, 64, 65, 513, 1025, 0};
		phase_items = '{170, 150, 30, 180, 40, 120, 120, 120, 150, 150, 150, 160, 150, 150};
		phase_len[PHASES-1] = $urandom_range(0, 2047);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: full length from reset, edges of the store
		send_item(ACT_SET, 10'd0, 7'd0, 8'd0);
		send_item(ACT_SET, 10'd1023, 7'd0, 8'd0);
		send_item(ACT_TEST, 10'd0, 7'd0, 8'd0);
		send_item(ACT_TEST, 10'd1023, 7'd0, 8'd0);
		send_item(ACT_TEST, 10'd512, 7'd0, 8'd0);
		send_item(ACT_COUNT, 10'd0, 7'd0, 8'd0);
		send_item(ACT_FIND, 10'd0, 7'd0, 8'd0);
		send_item(ACT_FIND, 10'd1023, 7'd0, 8'd0);
		send_item(ACT_CLR, 10'd0, 7'd0, 8'd0);
		send_item(ACT_FIND, 10'd0, 7'd0, 8'd0);
		send_item(ACT_BYTE, 10'd0, 7'd0, 8'hFF);
		send_item(ACT_BYTE, 10'd0, 7'd127, 8'hA5);
		send_item(ACT_COUNT, 10'd0, 7'd0, 8'd0);
		send_item(ACT_FIND, 10'd1017, 7'd0, 8'd0);
		send_item(ACT_CLR, 10'd1023, 7'd0, 8'd0);
		// unused codes with every field bit high
		send_item(ACT_SPARE_A, 10'h3FF, 7'h7F, 8'hFF);
		send_item(ACT_SPARE_B, 10'h3FF, 7'h7F, 8'hFF);

		// empty length: everything ignored or out of range
		set_length(0);
		send_item(ACT_SET, 10'd5, 7'd0, 8'd0);
		send_item(ACT_BYTE, 10'd0, 7'd0, 8'hFF);
		send_item(ACT_TEST, 10'd0, 7'd0, 8'd0);
		send_item(ACT_COUNT, 10'd0, 7'd0, 8'd0);
		send_item(ACT_FIND, 10'd0, 7'd0, 8'd0);

		// one bit in use: byte write stores bits past length, count and find mask them
		set_length(1);
		send_item(ACT_BYTE, 10'd0, 7'd0, 8'hFF);
		send_item(ACT_BYTE, 10'd0, 7'd1, 8'hFF);
		send_item(ACT_COUNT, 10'd0, 7'd0, 8'd0);
		send_item(ACT_FIND, 10'd1, 7'd0, 8'd0);
		send_item(ACT_TEST, 10'd1, 7'd0, 8'd0);

		// random phases over a spread of lengths
		for (int ph = 0; ph < PHASES; ph++) begin
			set_length(phase_len[ph]);
			steady = (ph == 3);
			if (ph == 5) begin
				// long response hold-off while items keep coming
				run_random_phase(40);
				hold_request = 1'b1;
				run_random_phase(phase_items[ph] - 40);
			end else if (ph == 8) begin
				// sender pause until the block has answered everything
				run_random_phase(phase_items[ph] / 2);
				drain_answers();
				run_random_phase(phase_items[ph] - phase_items[ph] / 2);
			end else begin
				run_random_phase(phase_items[ph]);
			end
		end
		steady = 1'b0;

		// wind down
		drain_answers();
		repeat (40) @(negedge clk);
		$display("run covered %0d items of all actions under %0d length settings", items_sent,
			settings_used);
		$display("%0d answers compared field by field", checked);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_bitmap_set_test_count_find: clean");
		end else begin
			$display("tb_bitmap_set_test_count_find: errors");
		end
		$finish;
	end

endmodule
